/* design/cfm_pkg.sv */
package cfm_pkg;

    localparam int CHANNELS = 4;

    localparam int CH_W    = 2;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 24;
    localparam int FREQ_W  = 24;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam int BIT_CNT_W = $clog2(FREQ_W);

    localparam logic [CFG_W-1:0] TICK_RATE_RESET = 24'd1000000;
    localparam logic [CFG_W-1:0] MIN_FREQ_RESET  = 24'd100;

    // register indexes on the configuration port
    localparam logic REG_TICK_RATE = 1'b0;
    localparam logic REG_MIN_FREQ  = 1'b1;

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

endpackage

/* design/capture_frequency_meter.sv */
// A first capture of a pair is absorbed with no result word; a second capture runs the
// bit-serial restoring divider in ST_DIV, then the min test in ST_FIN loads the output
// register. The next word is accepted only once that division and its result are done;
// the one-bit-per-cycle divider sets its length, and ST_FIN waits while the output stalls.
// reset (aresetn low, synchronous): channels disarmed, output empty, tick_rate 1000000, min_freq 100
module capture_frequency_meter
    import cfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // channel[1:0], capture_count[17:2], zero pad

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_channel[1:0], period[17:2],
                                            // frequency[41:18], zero pad

    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [1:0]           state_reg, state_next;
    logic [CFG_W-1:0]     tick_rate_reg;
    logic [CFG_W-1:0]     min_freq_reg;
    logic [CHANNELS-1:0]  armed_reg;
    logic [COUNT_W-1:0]   first_count_reg [CHANNELS];

    logic [CH_W-1:0]      ch_reg;
    logic [COUNT_W-1:0]   per_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [FREQ_W-1:0]    quo_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    logic                 m_tvalid_reg;
    logic [CH_W-1:0]      m_ch_reg;
    logic [COUNT_W-1:0]   m_per_reg;
    logic [FREQ_W-1:0]    m_freq_reg;

    logic [CH_W-1:0]      in_ch;
    logic [COUNT_W-1:0]   in_count;
    logic                 in_accept;
    logic                 ch_present;
    logic [COUNT_W-1:0]   diff;
    logic [COUNT_W-1:0]   per_calc;
    logic [COUNT_W:0]     rem_shift;
    logic                 rem_ge;
    logic [COUNT_W:0]     rem_sub;
    logic                 out_free;
    logic                 last_bit;

    assign in_ch      = s_tdata[CH_W-1:0];
    assign in_count   = s_tdata[CH_W+COUNT_W-1:CH_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign ch_present = (32'(in_ch) < CHANNELS);

    // wrapped period, equal counts read as one tick
    assign diff     = in_count - first_count_reg[in_ch];
    assign per_calc = (diff == '0) ? COUNT_W'(1) : diff;

    // one restoring division step per cycle
    assign rem_shift = {rem_reg, quo_reg[FREQ_W-1]};
    assign rem_sub   = rem_shift - {1'b0, per_reg};
    assign rem_ge    = (rem_shift >= {1'b0, per_reg});
    assign last_bit  = (bit_cnt_reg == BIT_CNT_W'(FREQ_W - 1));

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && ch_present && armed_reg[in_ch]) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (last_bit) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_rate_reg <= TICK_RATE_RESET;
            min_freq_reg  <= MIN_FREQ_RESET;
            armed_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_TICK_RATE: tick_rate_reg <= cfg_data;
                    REG_MIN_FREQ:  min_freq_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept && ch_present) begin
                armed_reg[in_ch] <= !armed_reg[in_ch];
            end
            if (state_reg == ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept && ch_present && !armed_reg[in_ch]) begin
            first_count_reg[in_ch] <= in_count;
        end
        if (state_reg == ST_IDLE) begin
            ch_reg      <= in_ch;
            per_reg     <= per_calc;
            rem_reg     <= '0;
            quo_reg     <= tick_rate_reg;
            bit_cnt_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            rem_reg     <= rem_ge ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quo_reg     <= {quo_reg[FREQ_W-2:0], rem_ge};
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
        end
        if (state_reg == ST_FIN && out_free) begin
            m_ch_reg   <= ch_reg;
            m_per_reg  <= per_reg;
            m_freq_reg <= (quo_reg < min_freq_reg) ? '0 : quo_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - CH_W - COUNT_W - FREQ_W)'(0),
                       m_freq_reg, m_per_reg, m_ch_reg};

    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CH_W+COUNT_W-1:CH_W] != '0))
        else $error("result word with zero period");

    a_freq_above_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=>
            (m_freq_reg == '0 || m_freq_reg >= min_freq_reg))
        else $error("nonzero frequency below min_freq");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && last_bit) |=> (state_reg == ST_FIN))
        else $error("divider did not finish after its last bit");

    a_second_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && ch_present && armed_reg[in_ch]) |=>
            (state_reg == ST_DIV && !armed_reg[ch_reg]))
        else $error("second capture did not start a division");

endmodule
